/* rtl/kpcc_pkg.sv */
`timescale 1ns / 1ps
package kpcc_pkg;

  localparam int unsigned MaxPairs = 1024;
  localparam int unsigned AddrW    = $clog2(MaxPairs);
  localparam int unsigned CountW   = AddrW + 1;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFew      = 2'd1,
    StatusZeroDen  = 2'd2,
    StatusOverflow = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               pair_valid;
    logic               last_pair;
  } pair_t;

  typedef struct packed {
    logic [18:0] concordant_pairs;
    logic [18:0] discordant_pairs;
    logic [18:0] x_only_ties;
    logic [18:0] y_only_ties;
    logic [10:0] kept_count;
    logic [19:0] x_group_pairs;
    logic [31:0] x_group_var;
    logic [29:0] x_group_cubic;
    logic [19:0] y_group_pairs;
    logic [31:0] y_group_var;
    logic [29:0] y_group_cubic;
    logic [1:0]  status;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic init;
    logic rd_row;
    logic latch_row;
    logic sweep;
    logic mom1;
    logic mom2;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few;
    logic b_last;
    logic a_last;
  } stat_t;

endpackage

/* rtl/kpcc_ctrl.sv */
`timescale 1ns / 1ps
module kpcc_ctrl import kpcc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  last_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy
);

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StInit   = 9'b000000010,
    StLoadA  = 9'b000000100,
    StLatchA = 9'b000001000,
    StSweep  = 9'b000010000,
    StDrain  = 9'b000100000,
    StMom1   = 9'b001000000,
    StMom2   = 9'b010000000,
    StEmit   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != StIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.store = start;
        if (start && last_i) state_d = StInit;
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d = stat_i.few ? StEmit : StLoadA;
      end
      StLoadA: begin
        cmd_o.rd_row = 1'b1;
        state_d = StLatchA;
      end
      StLatchA: begin
        cmd_o.latch_row = 1'b1;
        state_d = StSweep;
      end
      StSweep: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.b_last) state_d = StDrain;
      end
      StDrain: state_d = StMom1;
      StMom1: begin
        cmd_o.mom1 = 1'b1;
        state_d = StMom2;
      end
      StMom2: begin
        cmd_o.mom2 = 1'b1;
        state_d = stat_i.a_last ? StEmit : StLoadA;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/kpcc_dpath.sv */
`timescale 1ns / 1ps
module kpcc_dpath import kpcc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pair_t   pair_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output result_t result_o,
  output logic    result_valid_o
);

  logic [31:0] x_mem [MaxPairs];
  logic [31:0] y_mem [MaxPairs];
  logic [31:0] x_rd_q, y_rd_q, xa_q, ya_q;
  logic [CountW-1:0] n_q;
  logic ovf_q;
  logic [AddrW-1:0] a_q, b_q, pb_q, rd_addr;
  logic pend_q;
  logic [18:0] cp_q, dp_q, xt_q, yt_q;
  logic [AddrW-1:0] x_eq_q, y_eq_q;
  logic x_first_q, y_first_q;
  logic [CountW-1:0] tx_q, ty_q, tx, ty;
  logic [19:0] px_q, py_q;
  logic [19:0] xm0_q, ym0_q;
  logic [31:0] xm1_q, ym1_q, xv_prod, yv_prod;
  logic [29:0] xm2_q, ym2_q, xc_prod, yc_prod;
  logic [CountW-1:0] n_m1;
  logic ox_eq, oy_eq, ox_gt, oy_gt;
  logic zero_den;
  result_t res_q;
  logic valid_q;

  assign n_m1          = n_q - 1'b1;
  assign stat_o.few    = (n_q < CountW'(3));
  assign stat_o.b_last = ({1'b0, b_q} == n_m1);
  assign stat_o.a_last = ({1'b0, a_q} == n_m1);
  assign rd_addr       = cmd_i.rd_row ? a_q : b_q;

  // Sample store: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && pair_i.pair_valid && (n_q < CountW'(MaxPairs))) begin
      x_mem[n_q[AddrW-1:0]] <= pair_i.x_value;
      y_mem[n_q[AddrW-1:0]] <= pair_i.y_value;
    end
    x_rd_q <= x_mem[rd_addr];
    y_rd_q <= y_mem[rd_addr];
  end

  // Fill count and overflow flag for the current set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.emit) begin
      n_q   <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.store && pair_i.pair_valid) begin
      if (n_q < CountW'(MaxPairs)) n_q <= n_q + 1'b1;
      else ovf_q <= 1'b1;
    end
  end

  // Order of the row sample against the swept sample.
  assign ox_eq = (x_rd_q == xa_q);
  assign oy_eq = (y_rd_q == ya_q);
  assign ox_gt = ($signed(x_rd_q) > $signed(xa_q));
  assign oy_gt = ($signed(y_rd_q) > $signed(ya_q));

  // Tie group sizes and their moment factors.
  assign tx = {1'b0, x_eq_q} + 1'b1;
  assign ty = {1'b0, y_eq_q} + 1'b1;
  assign xv_prod = 32'(px_q * ({tx_q, 1'b0} + 12'd5));
  assign yv_prod = 32'(py_q * ({ty_q, 1'b0} + 12'd5));
  assign xc_prod = 30'(px_q * (tx_q - 2'd2));
  assign yc_prod = 30'(py_q * (ty_q - 2'd2));

  // Row and sweep counters, pair counts and tie moments.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    pb_q <= b_q;
    if (cmd_i.init) begin
      a_q   <= '0;
      cp_q  <= '0;
      dp_q  <= '0;
      xt_q  <= '0;
      yt_q  <= '0;
      xm0_q <= '0;
      xm1_q <= '0;
      xm2_q <= '0;
      ym0_q <= '0;
      ym1_q <= '0;
      ym2_q <= '0;
    end
    if (cmd_i.latch_row) begin
      xa_q      <= x_rd_q;
      ya_q      <= y_rd_q;
      b_q       <= '0;
      x_eq_q    <= '0;
      y_eq_q    <= '0;
      x_first_q <= 1'b1;
      y_first_q <= 1'b1;
    end
    if (cmd_i.sweep) b_q <= b_q + 1'b1;
    if (pend_q) begin
      if (pb_q > a_q) begin
        if (ox_eq) x_eq_q <= x_eq_q + 1'b1;
        if (oy_eq) y_eq_q <= y_eq_q + 1'b1;
        if (ox_eq && !oy_eq) xt_q <= xt_q + 1'b1;
        else if (oy_eq && !ox_eq) yt_q <= yt_q + 1'b1;
        else if (!ox_eq && !oy_eq) begin
          if (ox_gt == oy_gt) cp_q <= cp_q + 1'b1;
          else dp_q <= dp_q + 1'b1;
        end
      end else if (pb_q < a_q) begin
        if (ox_eq) x_first_q <= 1'b0;
        if (oy_eq) y_first_q <= 1'b0;
      end
    end
    if (cmd_i.mom1) begin
      tx_q <= tx;
      ty_q <= ty;
      px_q <= 20'(tx * (tx - 1'b1));
      py_q <= 20'(ty * (ty - 1'b1));
    end
    if (cmd_i.mom2) begin
      if (x_first_q && (tx_q > CountW'(1))) begin
        xm0_q <= xm0_q + px_q;
        xm1_q <= xm1_q + xv_prod;
        xm2_q <= xm2_q + xc_prod;
      end
      if (y_first_q && (ty_q > CountW'(1))) begin
        ym0_q <= ym0_q + py_q;
        ym1_q <= ym1_q + yv_prod;
        ym2_q <= ym2_q + yc_prod;
      end
      a_q <= a_q + 1'b1;
    end
  end

  assign zero_den = ((cp_q + dp_q + xt_q) == '0) || ((cp_q + dp_q + yt_q) == '0);

  // Result register, loaded on emit; its valid strobe is shown for one cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.kept_count <= n_q;
      if (stat_o.few) begin
        res_q.concordant_pairs <= '0;
        res_q.discordant_pairs <= '0;
        res_q.x_only_ties      <= '0;
        res_q.y_only_ties      <= '0;
        res_q.x_group_pairs    <= '0;
        res_q.x_group_var      <= '0;
        res_q.x_group_cubic    <= '0;
        res_q.y_group_pairs    <= '0;
        res_q.y_group_var      <= '0;
        res_q.y_group_cubic    <= '0;
        res_q.status           <= StatusFew;
      end else begin
        res_q.concordant_pairs <= cp_q;
        res_q.discordant_pairs <= dp_q;
        res_q.x_only_ties      <= xt_q;
        res_q.y_only_ties      <= yt_q;
        res_q.x_group_pairs    <= xm0_q;
        res_q.x_group_var      <= xm1_q;
        res_q.x_group_cubic    <= xm2_q;
        res_q.y_group_pairs    <= ym0_q;
        res_q.y_group_var      <= ym1_q;
        res_q.y_group_cubic    <= ym2_q;
        if (ovf_q) res_q.status <= StatusOverflow;
        else if (zero_den) res_q.status <= StatusZeroDen;
        else res_q.status <= StatusOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = valid_q;

endmodule

/* rtl/kendall_pair_concordance_counter.sv */
`timescale 1ns / 1ps
// Loading: one pair per cycle while busy is low; items without last_pair leave busy low.
// Counting: after a last item, busy stays high through an init step, then for each
// stored row a load, a latch, one sweep of the sample store (one read a cycle), a
// drain and the mom1 and mom2 steps, then emit (init then emit alone below three pairs).
// The result strobe comes in the first cycle with busy low; it cannot be stalled.
// Reset (asynchronous, active low) empties the set and returns to idle.
module kendall_pair_concordance_counter import kpcc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  pair_t   pair_i,
  output logic    busy,
  output result_t result_o,
  output logic    result_valid_o
);

  cmd_t  cmd;
  stat_t stat;

  kpcc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .last_i (pair_i.last_pair),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  kpcc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pair_i         (pair_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

/* rtl/kpcc_checker.sv */
`timescale 1ns / 1ps
module kpcc_checker import kpcc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input pair_t   pair_i,
  input logic    busy,
  input result_t result_o,
  input logic    result_valid_o
);

  // A last item always starts a counting transaction.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && pair_i.last_pair |=> busy)
    else $error("last item did not start counting");

  // A result comes only at the end of a busy period.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy) && !busy)
    else $error("result outside end of count");

  // Strobe lasts a single cycle.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // Fewer than three pairs gives the short-set status and a zero concordant count.
  a_few: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.kept_count < 11'd3) |->
      (result_o.status == StatusFew) && (result_o.concordant_pairs == '0))
    else $error("short set result wrong");

endmodule

bind kendall_pair_concordance_counter kpcc_checker u_kpcc_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import kpcc_pkg::*;

  localparam int unsigned ItemGoal   = 1900;
  localparam longint      CycleLimit = 4_000_000;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  pair_t   pair_i;
  logic    busy;
  result_t result_o;
  logic    result_valid_o;

  kendall_pair_concordance_counter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .pair_i        (pair_i),
    .busy          (busy),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  // Predictor state: the samples of the set being loaded.
  logic signed [31:0] set_x[$];
  logic signed [31:0] set_y[$];
  logic               set_overflow;
  result_t            pending_results[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned sets_done;
  int unsigned results_seen;
  longint      cycles;
  bit          burst_mode;

  // Directed rows; typed_result is used instead of the predictor where set.
  typedef struct {
    pair_t   item;
    bit      typed;
    result_t typed_result;
  } stim_row_t;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sum of t(t-1), t(t-1)(2t+5) and t(t-1)(t-2) over groups of equal keys.
  function automatic void group_moments(input logic signed [31:0] keys[$],
                                        output longint m_pairs, output longint m_var,
                                        output longint m_cubic);
    longint t;
    bit     seen;
    m_pairs = 0;
    m_var   = 0;
    m_cubic = 0;
    for (int i = 0; i < keys.size(); i++) begin
      seen = 0;
      t    = 1;
      for (int j = 0; j < keys.size(); j++) begin
        if (j != i && keys[j] == keys[i]) begin
          if (j < i) seen = 1;
          else t++;
        end
      end
      if (!seen && t > 1) begin
        m_pairs += t * (t - 1);
        m_var   += t * (t - 1) * (2 * t + 5);
        m_cubic += t * (t - 1) * (t - 2);
      end
    end
  endfunction

  // Counts the pairs of the stored set and forms the result of a finished set.
  function automatic result_t count_set();
    result_t r;
    longint  conc, disc, xt, yt, m0, m1, m2;
    int      n;
    conc = 0; disc = 0; xt = 0; yt = 0;
    r = '0;
    n = set_x.size();
    r.kept_count = n[10:0];
    if (n < 3) begin
      r.status = StatusFew;
      return r;
    end
    for (int a = 0; a + 1 < n; a++) begin
      for (int b = a + 1; b < n; b++) begin
        if (set_x[a] == set_x[b] && set_y[a] == set_y[b]) continue;
        if (set_x[a] == set_x[b]) xt++;
        else if (set_y[a] == set_y[b]) yt++;
        else if ((set_x[a] < set_x[b]) == (set_y[a] < set_y[b])) conc++;
        else disc++;
      end
    end
    r.concordant_pairs = conc[18:0];
    r.discordant_pairs = disc[18:0];
    r.x_only_ties      = xt[18:0];
    r.y_only_ties      = yt[18:0];
    group_moments(set_x, m0, m1, m2);
    r.x_group_pairs = m0[19:0];
    r.x_group_var   = m1[31:0];
    r.x_group_cubic = m2[29:0];
    group_moments(set_y, m0, m1, m2);
    r.y_group_pairs = m0[19:0];
    r.y_group_var   = m1[31:0];
    r.y_group_cubic = m2[29:0];
    if (set_overflow) r.status = StatusOverflow;
    else if (conc + disc + xt == 0 || conc + disc + yt == 0) r.status = StatusZeroDen;
    else r.status = StatusOk;
    return r;
  endfunction

  // Applies one accepted transaction to the predictor state.
  function automatic void absorb_pair(input pair_t p, input bit typed, input result_t tr);
    if (p.pair_valid) begin
      if (set_x.size() < MaxPairs) begin
        set_x = {set_x, p.x_value};
        set_y = {set_y, p.y_value};
      end else begin
        set_overflow = 1;
      end
    end
    if (p.last_pair) begin
      pending_results = {pending_results, (typed ? tr : count_set())};
      set_x.delete();
      set_y.delete();
      set_overflow = 0;
      sets_done++;
    end
  endfunction

  // Sends one transaction after a random gap (none in burst mode); start stays high across back-to-back items.
  task automatic send_pair(input pair_t p, input bit typed = 0, input result_t tr = '0);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pair_i <= p;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    absorb_pair(p, typed, tr);
    items_sent++;
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result checker: each strobe is compared with the oldest expected result.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, result_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("concordant_pairs", e.concordant_pairs, result_o.concordant_pairs);
        check_field("discordant_pairs", e.discordant_pairs, result_o.discordant_pairs);
        check_field("x_only_ties", e.x_only_ties, result_o.x_only_ties);
        check_field("y_only_ties", e.y_only_ties, result_o.y_only_ties);
        check_field("kept_count", e.kept_count, result_o.kept_count);
        check_field("x_group_pairs", e.x_group_pairs, result_o.x_group_pairs);
        check_field("x_group_var", e.x_group_var, result_o.x_group_var);
        check_field("x_group_cubic", e.x_group_cubic, result_o.x_group_cubic);
        check_field("y_group_pairs", e.y_group_pairs, result_o.y_group_pairs);
        check_field("y_group_var", e.y_group_var, result_o.y_group_var);
        check_field("y_group_cubic", e.y_group_cubic, result_o.y_group_cubic);
        check_field("status", e.status, result_o.status);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Random key: a value from the given pool, shifted down by two, or a full-range word.
  function automatic logic signed [31:0] draw_key(input int unsigned pool);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed(32'($urandom_range(0, pool))) - 32'sd2;
  endfunction

  function automatic pair_t make_pair(input logic signed [31:0] xv,
                                      input logic signed [31:0] yv,
                                      input bit ok, input bit fin);
    pair_t p;
    p.x_value    = xv;
    p.y_value    = yv;
    p.pair_valid = ok;
    p.last_pair  = fin;
    return p;
  endfunction

  initial begin
    stim_row_t   rows[$];
    stim_row_t   row;
    result_t     few0, few2;
    int unsigned set_len, pool;
    bit          fin;

    errors = 0; items_sent = 0; sets_done = 0; results_seen = 0; cycles = 0;
    burst_mode = 0;
    set_overflow = 0;
    start  = 1'b0;
    pair_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    few0 = '0;
    few0.status = StatusFew;
    few2 = few0;
    few2.kept_count = 11'd2;

    // Directed table.
    rows = {rows, stim_row_t'{make_pair(32'sd5, 32'sd5, 0, 1), 1, few0}};
    rows = {rows, stim_row_t'{make_pair(32'sh8000_0000, 32'sh7fff_ffff, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sh7fff_ffff, 32'sh8000_0000, 1, 1), 1, few2}};
    // Extremes of both keys, ending on a dropped last item.
    rows = {rows, stim_row_t'{make_pair(32'sh8000_0000, 32'sh8000_0000, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd0, 32'sh8000_0000, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sh7fff_ffff, 32'sd1, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd0, 32'sd0, 0, 1), 0, '0}};
    // All pairs tied on y: zero denominator.
    rows = {rows, stim_row_t'{make_pair(32'sd1, 32'sd7, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd2, 32'sd7, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd3, 32'sd7, 1, 1), 0, '0}};
    // All pairs tied on both sides.
    rows = {rows, stim_row_t'{make_pair(-32'sd4, -32'sd4, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(-32'sd4, -32'sd4, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(-32'sd4, -32'sd4, 1, 1), 0, '0}};
    // Mixed ties on x and y.
    rows = {rows, stim_row_t'{make_pair(32'sd1, 32'sd3, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd1, 32'sd2, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd2, 32'sd2, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd3, 32'sd1, 1, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd1, 32'sd9, 0, 0), 0, '0}};
    rows = {rows, stim_row_t'{make_pair(32'sd4, 32'sd5, 1, 1), 0, '0}};
    foreach (rows[i]) begin
      row = rows[i];
      send_pair(row.item, row.typed, row.typed_result);
    end
    drain_results();

    // Store overflow: more valid pairs than the store holds, loaded back to back.
    burst_mode = 1;
    for (int i = 0; i < MaxPairs + 3; i++)
      send_pair(make_pair(draw_key(40), draw_key(40), 1, 0));
    burst_mode = 0;
    send_pair(make_pair(32'sd0, 32'sd0, 0, 1));
    drain_results();

    // Random sets, mostly well formed, some tiny, with bursts of zero gap.
    while (items_sent < ItemGoal) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       set_len = $urandom_range(1, 3);
        1:       set_len = $urandom_range(25, 60);
        default: set_len = $urandom_range(4, 24);
      endcase
      pool = $urandom_range(0, 1) ? $urandom_range(1, 6) : 1000;
      for (int i = 0; i < set_len; i++) begin
        fin = (i == set_len - 1);
        send_pair(make_pair(draw_key(pool), draw_key(pool), $urandom_range(0, 9) != 0, fin));
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    burst_mode = 0;

    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d transactions in %0d sets, checked %0d results,", items_sent,
             sets_done, results_seen);
    $display("including short sets, tie-only sets and a store overflow.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
